// ----- hw/rtl/gjk_pkg.sv -----
`default_nettype none

package gjk_pkg;

  // Widths fixed by the stream format.
  localparam int FIELD_W  = 18;
  localparam int DIR_W    = 64;
  localparam int ITER_W   = 11;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 3;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 200;

  localparam logic [ITER_W-1:0] ITER_RESET  = 11'd32;
  localparam logic [CNT_W-1:0]  SIMPLEX_MAX = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_SEARCH    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SEPARATED = 2'd1;
  localparam logic [STAT_W-1:0] ST_COLLIDED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_LIMIT     = 2'd3;

  // Input command codes.
  localparam logic CMD_START = 1'b0;

  // Last product index of a cross product (3 components x 2 terms x 2 halves)
  // and of a dot product (3 components x 2 halves).
  localparam logic [3:0] CROSS_LAST = 4'd11;
  localparam logic [3:0] DOT_LAST   = 4'd5;

  // Wide operand of the shared multiplier.
  typedef enum logic [2:0] {W_AB, W_AC, W_AD, W_T, W_ABC, W_DIR} wsel_t;
  // Narrow operand of the shared multiplier.
  typedef enum logic [2:0] {N_AB, N_AC, N_AD, N_AO, N_P} nsel_t;
  // Where a cross product lands.
  typedef enum logic [1:0] {D_NONE, D_T, D_ABC, D_DIR} dest_t;

  typedef struct packed {
    logic  is_dot;
    wsel_t wsel;
    nsel_t nsel;
    logic  neg;
    dest_t dest;
  } op_t;

  // Control that travels with one registered partial product.
  typedef struct packed {
    logic       valid;
    logic       hi;
    logic       neg;
    logic       first;
    logic       last;
    logic       is_dot;
    logic [1:0] comp;
    dest_t      dest;
  } pctl_t;

  function automatic op_t mk_op(logic is_dot, wsel_t w, nsel_t n, logic neg, dest_t d);
    op_t o;
    o.is_dot = is_dot;
    o.wsel   = w;
    o.nsel   = n;
    o.neg    = neg;
    o.dest   = d;
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gjk_simplex_refinement.sv -----
// GJK simplex refinement for 3-D collision detection.
// The input stream carries one support point of the Minkowski difference per
// word: in_tdata holds x, y, z and in_tuser the command (start or next point).
// Every accepted word yields exactly one result word on the output stream:
// out_tuser holds the status, out_tdata the search direction and the count of
// points held in the simplex.
// The iteration cap is written on the cfg channel, which is always ready.
// A start word, and a next word that only repeats an ended search or hits the
// cap, goes from acceptance straight to the output state; the input stays
// blocked until its result is loaded into the output register. A next word
// runs the line, triangle or tetrahedron reduction on one shared 33 x 19 bit
// multiplier with an accumulator: a dot product is issued as six partial
// products and a cross product as twelve, each followed by a drain state. The
// shortest path is a point behind the direction, the longest a tetrahedron
// falling back to a triangle and then to a line, plus any wait for the output.
// in_tready is high only while the sequencer is idle; one word is in work at
// a time. A finished result sits in the output register, so the next word is
// taken while the receiver stalls; that next result waits until the register
// frees up.
// Reset (synchronous, active low) empties the simplex, zeroes the direction,
// sets the status to searching and the iteration cap to 32.
`default_nettype none

module gjk_simplex_refinement #(
  parameter int COORD_BITS = 18
) (
  input  wire         clk,
  input  wire         rst_n,
  // Fields from bit 0: support_x, support_y, support_z, zero fill.
  input  wire  [55:0] in_tdata,
  // Fields from bit 0: command.
  input  wire  [0:0]  in_tuser,
  input  wire         in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: dir_x, dir_y, dir_z, simplex_count, zero fill.
  output logic [199:0] out_tdata,
  // Fields from bit 0: status.
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  input  wire  [10:0] cfg_data,
  input  wire         cfg_valid,
  output logic        cfg_ready
);

  localparam int NW    = COORD_BITS + 1;
  localparam int CW    = 33;
  localparam int PW    = CW + NW;
  localparam int ACC_W = 67 + NW;
  localparam int DW    = gjk_pkg::DIR_W;
  localparam int FW    = gjk_pkg::FIELD_W;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_DRAIN, S_CHKP, S_RED,
    S_L1, S_L2,
    S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7,
    S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_Q6,
    S_FIN, S_OUT
  } state_t;

  state_t state_r;
  state_t ret_r;
  gjk_pkg::op_t   op_r;
  gjk_pkg::pctl_t pctl_r;
  gjk_pkg::pctl_t pctl_nxt;

  logic signed [COORD_BITS-1:0] pts_r [4][3];
  logic signed [COORD_BITS-1:0] p_r [3];
  logic signed [COORD_BITS-1:0] in_p [3];
  logic signed [DW-1:0] dir_r [3];
  logic signed [DW-1:0] t_r [3];
  logic signed [DW-1:0] abc_r [3];

  logic [gjk_pkg::CNT_W-1:0]  count_r;
  logic [gjk_pkg::ITER_W-1:0] step_r;
  logic [gjk_pkg::ITER_W-1:0] max_r;
  logic [gjk_pkg::STAT_W-1:0] status_r;

  logic [3:0] sidx_r;
  logic       pos_r;
  logic       neg_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    prod_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_nxt;

  logic signed [NW-1:0] ab [3];
  logic signed [NW-1:0] ac [3];
  logic signed [NW-1:0] ad [3];
  logic signed [NW-1:0] ao [3];

  logic [1:0] icomp;
  logic [1:0] wcomp;
  logic [1:0] ncomp;
  logic       iterm;
  logic       ihi;
  logic       ilast;
  logic signed [DW-1:0] wval;
  logic signed [NW-1:0] nval;
  logic signed [CW-1:0] chunk;

  logic                        out_valid_r;
  logic [gjk_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [gjk_pkg::STAT_W-1:0]  out_stat_r;

  logic in_acc;
  logic start;
  logic out_load;

  function automatic logic [1:0] rot1(logic [1:0] c);
    unique case (c)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] rot2(logic [1:0] c);
    unique case (c)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  // Ports.
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  assign in_acc   = in_tvalid && in_tready;
  assign start    = (in_tuser[0] == gjk_pkg::CMD_START) || (count_r == '0);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Edge vectors of the simplex and the incoming point, low bits of each field.
  for (genvar i = 0; i < 3; i++) begin : g_vec
    assign in_p[i] = in_tdata[i*FW +: COORD_BITS];
    assign ab[i] = NW'(pts_r[1][i]) - NW'(pts_r[0][i]);
    assign ac[i] = NW'(pts_r[2][i]) - NW'(pts_r[0][i]);
    assign ad[i] = NW'(pts_r[3][i]) - NW'(pts_r[0][i]);
    assign ao[i] = -NW'(pts_r[0][i]);
  end

  // Decode the product index into components, term and half of the wide word.
  always_comb begin
    if (op_r.is_dot) begin
      icomp = sidx_r[2:1];
      iterm = 1'b0;
      ihi   = sidx_r[0];
      wcomp = icomp;
      ncomp = icomp;
      ilast = (sidx_r == gjk_pkg::DOT_LAST);
      pctl_nxt.first = (sidx_r == '0);
      pctl_nxt.last  = ilast;
    end else begin
      icomp = sidx_r[3:2];
      iterm = sidx_r[1];
      ihi   = sidx_r[0];
      wcomp = iterm ? rot2(icomp) : rot1(icomp);
      ncomp = iterm ? rot1(icomp) : rot2(icomp);
      ilast = (sidx_r == gjk_pkg::CROSS_LAST);
      pctl_nxt.first = !iterm && !ihi;
      pctl_nxt.last  = iterm && ihi;
    end
    pctl_nxt.valid  = 1'b1;
    pctl_nxt.hi     = ihi;
    pctl_nxt.neg    = iterm ^ op_r.neg;
    pctl_nxt.is_dot = op_r.is_dot;
    pctl_nxt.comp   = icomp;
    pctl_nxt.dest   = op_r.dest;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (op_r.wsel)
      gjk_pkg::W_AB:  wval = DW'(ab[wcomp]);
      gjk_pkg::W_AC:  wval = DW'(ac[wcomp]);
      gjk_pkg::W_AD:  wval = DW'(ad[wcomp]);
      gjk_pkg::W_T:   wval = t_r[wcomp];
      gjk_pkg::W_ABC: wval = abc_r[wcomp];
      gjk_pkg::W_DIR: wval = dir_r[wcomp];
      default:        wval = '0;
    endcase
    case (op_r.nsel)
      gjk_pkg::N_AB: nval = ab[ncomp];
      gjk_pkg::N_AC: nval = ac[ncomp];
      gjk_pkg::N_AD: nval = ad[ncomp];
      gjk_pkg::N_AO: nval = ao[ncomp];
      gjk_pkg::N_P:  nval = NW'(p_r[ncomp]);
      default:       nval = '0;
    endcase
    chunk = ihi ? {wval[DW-1], wval[DW-1:32]} : {1'b0, wval[31:0]};
  end

  assign prod_nxt = chunk * nval;

  // Accumulate the registered partial product.
  always_comb begin
    term = pctl_r.hi ? (ACC_W'(prod_r) <<< 32) : ACC_W'(prod_r);
    if (pctl_r.neg) begin
      term = -term;
    end
    acc_nxt = (pctl_r.first ? '0 : acc_r) + term;
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      op_r        <= '0;
      pctl_r      <= '0;
      sidx_r      <= '0;
      count_r     <= '0;
      step_r      <= '0;
      status_r    <= gjk_pkg::ST_SEARCH;
      max_r       <= gjk_pkg::ITER_RESET;
      out_valid_r <= 1'b0;
      pos_r       <= 1'b0;
      neg_r       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        dir_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        max_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      // Partial-product pipeline stage.
      if (state_r == S_EXEC) begin
        pctl_r <= pctl_nxt;
        prod_r <= prod_nxt;
      end else begin
        pctl_r.valid <= 1'b0;
      end
      if (pctl_r.valid) begin
        acc_r <= acc_nxt;
        if (pctl_r.last) begin
          if (pctl_r.is_dot) begin
            neg_r <= acc_nxt[ACC_W-1];
            pos_r <= !acc_nxt[ACC_W-1] && (acc_nxt != '0);
          end else begin
            case (pctl_r.dest)
              gjk_pkg::D_T:   t_r[pctl_r.comp]   <= acc_nxt[DW-1:0];
              gjk_pkg::D_ABC: abc_r[pctl_r.comp] <= acc_nxt[DW-1:0];
              gjk_pkg::D_DIR: dir_r[pctl_r.comp] <= acc_nxt[DW-1:0];
              default: ;
            endcase
          end
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (start) begin
              for (int i = 0; i < 3; i++) begin
                pts_r[0][i] <= in_p[i];
                dir_r[i]    <= -DW'(in_p[i]);
              end
              count_r  <= 3'd1;
              step_r   <= '0;
              status_r <= gjk_pkg::ST_SEARCH;
              state_r  <= S_OUT;
            end else if (status_r != gjk_pkg::ST_SEARCH) begin
              state_r <= S_OUT;
            end else if (step_r >= max_r) begin
              status_r <= gjk_pkg::ST_LIMIT;
              state_r  <= S_OUT;
            end else begin
              for (int i = 0; i < 3; i++) begin
                p_r[i] <= in_p[i];
              end
              op_r    <= gjk_pkg::mk_op(1'b1, gjk_pkg::W_DIR, gjk_pkg::N_P, 1'b0,
                                        gjk_pkg::D_NONE);
              ret_r   <= S_CHKP;
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (ilast) begin
            sidx_r  <= '0;
            state_r <= S_DRAIN;
          end else begin
            sidx_r <= sidx_r + 4'd1;
          end
        end
        S_DRAIN: begin
          state_r <= ret_r;
        end
        // Point behind the direction: separated. Otherwise push it.
        S_CHKP: begin
          if (neg_r) begin
            status_r <= gjk_pkg::ST_SEPARATED;
            state_r  <= S_OUT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              pts_r[3][i] <= pts_r[2][i];
              pts_r[2][i] <= pts_r[1][i];
              pts_r[1][i] <= pts_r[0][i];
              pts_r[0][i] <= p_r[i];
            end
            if (count_r < gjk_pkg::SIMPLEX_MAX) begin
              count_r <= count_r + 3'd1;
            end
            step_r  <= step_r + 11'd1;
            state_r <= S_RED;
          end
        end
        // Dispatch on the simplex size.
        S_RED: begin
          state_r <= S_EXEC;
          if (count_r == 3'd2) begin
            op_r  <= gjk_pkg::mk_op(1'b1, gjk_pkg::W_AB, gjk_pkg::N_AO, 1'b0,
                                    gjk_pkg::D_NONE);
            ret_r <= S_L1;
          end else if (count_r == 3'd3) begin
            op_r  <= gjk_pkg::mk_op(1'b0, gjk_pkg::W_AB, gjk_pkg::N_AC, 1'b0,
                                    gjk_pkg::D_ABC);
            ret_r <= S_T1;
          end else begin
            op_r  <= gjk_pkg::mk_op(1'b0, gjk_pkg::W_AB, gjk_pkg::N_AC, 1'b0,
                                    gjk_pkg::D_T);
            ret_r <= S_Q1;
          end
        end
        // Line case.
        S_L1: begin
          if (pos_r) begin
            op_r    <= gjk_pkg::mk_op(1'b0, gjk_pkg::W_AB, gjk_pkg::N_AO, 1'b0,
                                      gjk_pkg::D_T);
            ret_r   <= S_L2;
            state_r <= S_EXEC;
          end else begin
            count_r <= 3'd1;
            for (int i = 0; i < 3; i++) begin
              dir_r[i] <= DW'(ao[i]);
            end
            state_r <= S_FIN;
          end
        end
        S_L2: begin
          op_r    <= gjk_pkg::mk_op(1'b0, gjk_pkg::W_T, gjk_pkg::N_AB, 1'b0,
                                    gjk_pkg::D_DIR);
          ret_r   <= S_FIN;
          state_r <= S_EXEC;
        end
        // Triangle case.
        S_T1: begin
          op_r    <= gjk_pkg::mk_op(1'b0, gjk_pkg::W_ABC, gjk_pkg::N_AC, 1'b0,
                                    gjk_pkg::D_T);
          ret_r   <= S_T2;
          state_r <= S_EXEC;
        end
        S_T2: begin
          op_r    <= gjk_pkg::mk_op(1'b1, gjk_pkg::W_T, gjk_pkg::N_AO, 1'b0,
                                    gjk_pkg::D_NONE);
          ret_r   <= S_T3;
          state_r <= S_EXEC;
        end
        S_T3: begin
          state_r <= S_EXEC;
          if (pos_r) begin
            op_r  <= gjk_pkg::mk_op(1'b1, gjk_pkg::W_AC, gjk_pkg::N_AO, 1'b0,
                                    gjk_pkg::D_NONE);
            ret_r <= S_T4;
          end else begin
            // Edge normal ab x abc, formed as -(abc x ab).
            op_r  <= gjk_pkg::mk_op(1'b0, gjk_pkg::W_ABC, gjk_pkg::N_AB, 1'b1,
                                    gjk_pkg::D_T);
            ret_r <= S_T5;
          end
        end
        S_T4: begin
          // Keep edge ac or edge ab, then run the line case on it.
          if (pos_r) begin
            for (int i = 0; i < 3; i++) begin
              pts_r[1][i] <= pts_r[2][i];
            end
          end
          count_r <= 3'd2;
          state_r <= S_RED;
        end
        S_T5: begin
          op_r    <= gjk_pkg::mk_op(1'b1, gjk_pkg::W_T, gjk_pkg::N_AO, 1'b0,
                                    gjk_pkg::D_NONE);
          ret_r   <= S_T6;
          state_r <= S_EXEC;
        end
        S_T6: begin
          if (pos_r) begin
            count_r <= 3'd2;
            state_r <= S_RED;
          end else begin
            op_r    <= gjk_pkg::mk_op(1'b1, gjk_pkg::W_ABC, gjk_pkg::N_AO, 1'b0,
                                      gjk_pkg::D_NONE);
            ret_r   <= S_T7;
            state_r <= S_EXEC;
          end
        end
        S_T7: begin
          // Origin above or below the face; below flips the winding.
          for (int i = 0; i < 3; i++) begin
            if (pos_r) begin
              dir_r[i] <= abc_r[i];
            end else begin
              dir_r[i]    <= -abc_r[i];
              pts_r[1][i] <= pts_r[2][i];
              pts_r[2][i] <= pts_r[1][i];
            end
          end
          state_r <= S_FIN;
        end
        // Tetrahedron case: test the three faces through the newest point.
        S_Q1, S_Q3, S_Q5: begin
          op_r    <= gjk_pkg::mk_op(1'b1, gjk_pkg::W_T, gjk_pkg::N_AO, 1'b0,
                                    gjk_pkg::D_NONE);
          ret_r   <= (state_r == S_Q1) ? S_Q2 : ((state_r == S_Q3) ? S_Q4 : S_Q6);
          state_r <= S_EXEC;
        end
        S_Q2: begin
          if (pos_r) begin
            count_r <= 3'd3;
            state_r <= S_RED;
          end else begin
            op_r    <= gjk_pkg::mk_op(1'b0, gjk_pkg::W_AC, gjk_pkg::N_AD, 1'b0,
                                      gjk_pkg::D_T);
            ret_r   <= S_Q3;
            state_r <= S_EXEC;
          end
        end
        S_Q4: begin
          if (pos_r) begin
            for (int i = 0; i < 3; i++) begin
              pts_r[1][i] <= pts_r[2][i];
              pts_r[2][i] <= pts_r[3][i];
            end
            count_r <= 3'd3;
            state_r <= S_RED;
          end else begin
            op_r    <= gjk_pkg::mk_op(1'b0, gjk_pkg::W_AD, gjk_pkg::N_AB, 1'b0,
                                      gjk_pkg::D_T);
            ret_r   <= S_Q5;
            state_r <= S_EXEC;
          end
        end
        S_Q6: begin
          if (pos_r) begin
            for (int i = 0; i < 3; i++) begin
              pts_r[1][i] <= pts_r[3][i];
              pts_r[2][i] <= pts_r[1][i];
            end
            count_r <= 3'd3;
            state_r <= S_RED;
          end else begin
            status_r <= gjk_pkg::ST_COLLIDED;
            state_r  <= S_OUT;
          end
        end
        S_FIN: begin
          if (step_r >= max_r) begin
            status_r <= gjk_pkg::ST_LIMIT;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_stat_r <= status_r;
            out_data_r <= {5'b0, count_r, dir_r[2], dir_r[1], dir_r[0]};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= gjk_pkg::SIMPLEX_MAX)
    else $error("simplex count above four");

  a_collided_full: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == gjk_pkg::ST_COLLIDED) |-> (count_r == gjk_pkg::SIMPLEX_MAX))
    else $error("collision reported without a full tetrahedron");

  a_pipe_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    pctl_r.valid |-> $past(state_r == S_EXEC))
    else $error("partial product issued outside the execute state");

  a_ended_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != gjk_pkg::ST_SEARCH) |-> (count_r != '0))
    else $error("search ended with an empty simplex");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_gjk_simplex_refinement.sv -----
`timescale 1ns / 1ps

typedef struct {
  logic [1:0]         status;
  logic signed [63:0] dx;
  logic signed [63:0] dy;
  logic signed [63:0] dz;
  logic [2:0]         count;
} gjk_result_t;

typedef struct {
  logic signed [63:0] x;
  logic signed [63:0] y;
  logic signed [63:0] z;
} vec_t;

// Scoreboard: holds the GJK state mirror and the queue of expected results.
class gjk_scoreboard;
  vec_t        pts[4];
  int unsigned npts;
  vec_t        sdir;
  int unsigned steps;
  logic [1:0]  fstat;
  int unsigned iter_cap;
  gjk_result_t pending[$];
  int          errors;
  int          checked;
  int          n_sep, n_coll, n_lim;

  function new();
    vec_t z;
    z.x = 0; z.y = 0; z.z = 0;
    for (int i = 0; i < 4; i++) pts[i] = z;
    npts = 0; sdir = z; steps = 0; fstat = gjk_pkg::ST_SEARCH; iter_cap = 32;
    errors = 0; checked = 0; n_sep = 0; n_coll = 0; n_lim = 0;
  endfunction

  function vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
    return r;
  endfunction

  function vec_t vneg(vec_t a);
    vec_t r;
    r.x = -a.x; r.y = -a.y; r.z = -a.z;
    return r;
  endfunction

  function vec_t vcross(vec_t a, vec_t b);
    vec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  // Exact dot sign from 128-bit products.
  function int dot_sign(vec_t a, vec_t b);
    logic signed [129:0] s;
    s = 130'(signed'(a.x)) * 130'(signed'(b.x)) + 130'(signed'(a.y)) * 130'(signed'(b.y))
      + 130'(signed'(a.z)) * 130'(signed'(b.z));
    if (s < 0) return -1;
    if (s == 0) return 0;
    return 1;
  endfunction

  function bit ahead(vec_t d, vec_t ao);
    return dot_sign(d, ao) > 0;
  endfunction

  function void fold_line();
    vec_t ab, ao;
    ab = vsub(pts[1], pts[0]);
    ao = vneg(pts[0]);
    if (ahead(ab, ao)) sdir = vcross(vcross(ab, ao), ab);
    else begin
      npts = 1;
      sdir = ao;
    end
  endfunction

  function void fold_triangle();
    vec_t a, b, c, ab, ac, ao, abc;
    a = pts[0]; b = pts[1]; c = pts[2];
    ab = vsub(b, a); ac = vsub(c, a); ao = vneg(a);
    abc = vcross(ab, ac);
    if (ahead(vcross(abc, ac), ao)) begin
      if (ahead(ac, ao)) begin
        pts[1] = c; npts = 2;
        sdir = vcross(vcross(ac, ao), ac);
      end else begin
        npts = 2;
        fold_line();
      end
    end else if (ahead(vcross(ab, abc), ao)) begin
      npts = 2;
      fold_line();
    end else if (ahead(abc, ao)) begin
      sdir = abc;
    end else begin
      pts[1] = c; pts[2] = b; npts = 3;
      sdir = vneg(abc);
    end
  endfunction

  function bit fold_tetra();
    vec_t a, b, c, d, ab, ac, ad, ao;
    a = pts[0]; b = pts[1]; c = pts[2]; d = pts[3];
    ab = vsub(b, a); ac = vsub(c, a); ad = vsub(d, a); ao = vneg(a);
    if (ahead(vcross(ab, ac), ao)) begin
      npts = 3; fold_triangle(); return 0;
    end
    if (ahead(vcross(ac, ad), ao)) begin
      pts[1] = c; pts[2] = d; npts = 3; fold_triangle(); return 0;
    end
    if (ahead(vcross(ad, ab), ao)) begin
      pts[1] = d; pts[2] = b; npts = 3; fold_triangle(); return 0;
    end
    return 1;
  endfunction

  // Note one accepted input word and queue its expected result.
  function void note_input(logic cmd, logic [17:0] px, logic [17:0] py, logic [17:0] pz);
    vec_t p;
    gjk_result_t r;
    bit hit;
    p.x = 64'(signed'(px)); p.y = 64'(signed'(py)); p.z = 64'(signed'(pz));
    if (cmd == gjk_pkg::CMD_START || npts == 0) begin
      pts[0] = p; npts = 1; sdir = vneg(p); steps = 0; fstat = gjk_pkg::ST_SEARCH;
    end else if (fstat == gjk_pkg::ST_SEARCH) begin
      if (steps >= iter_cap) fstat = gjk_pkg::ST_LIMIT;
      else if (dot_sign(p, sdir) < 0) fstat = gjk_pkg::ST_SEPARATED;
      else begin
        pts[3] = pts[2]; pts[2] = pts[1]; pts[1] = pts[0]; pts[0] = p;
        npts = (npts + 1 < 4) ? npts + 1 : 4;
        steps++;
        hit = 0;
        if (npts == 2) fold_line();
        else if (npts == 3) fold_triangle();
        else hit = fold_tetra();
        if (hit) fstat = gjk_pkg::ST_COLLIDED;
        else if (steps >= iter_cap) fstat = gjk_pkg::ST_LIMIT;
      end
    end
    r.status = fstat; r.dx = sdir.x; r.dy = sdir.y; r.dz = sdir.z; r.count = 3'(npts);
    pending.insert(pending.size(), r);
  endfunction

  task report(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Compare one result word with the oldest expectation.
  task check_result(logic [1:0] st, logic [199:0] d);
    gjk_result_t e;
    if (pending.size() == 0) begin
      report("result word with nothing expected");
      return;
    end
    e = pending.pop_front();
    checked++;
    case (st)
      gjk_pkg::ST_SEPARATED: n_sep++;
      gjk_pkg::ST_COLLIDED:  n_coll++;
      gjk_pkg::ST_LIMIT:     n_lim++;
      default: ;
    endcase
    if (st !== e.status) report($sformatf("status %0d, expected %0d", st, e.status));
    if (d[63:0] !== e.dx) report($sformatf("dir_x %0d, expected %0d", $signed(d[63:0]), e.dx));
    if (d[127:64] !== e.dy)
      report($sformatf("dir_y %0d, expected %0d", $signed(d[127:64]), e.dy));
    if (d[191:128] !== e.dz)
      report($sformatf("dir_z %0d, expected %0d", $signed(d[191:128]), e.dz));
    if (d[194:192] !== e.count)
      report($sformatf("simplex_count %0d, expected %0d", d[194:192], e.count));
    if (d[199:195] !== 5'd0) report("nonzero fill bits in out_tdata");
  endtask
endclass

module tb_gjk_simplex_refinement;
  logic         clk = 0;
  logic         rst_n = 0;
  logic [55:0]  in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [199:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [10:0]  cfg_data = '0;
  logic         cfg_valid = 0;
  logic         cfg_ready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  gjk_scoreboard sb;

  gjk_simplex_refinement uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  always #6 clk = ~clk;

  // Receiver side: random stalls, check every accepted result word.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one word; random gaps with valid low before it.
  task automatic send_word(logic cmd, logic [17:0] x, logic [17:0] y, logic [17:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, z, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, x, y, z);
  endtask

  // Let the pipeline drain before touching the register.
  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cap(logic [10:0] v);
    cfg_valid <= 1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.iter_cap = v;
  endtask

  function automatic logic [17:0] rnd_coord();
    case ($urandom_range(5))
      0: return 18'($urandom_range(0, 40) - 20);
      1: return 18'($urandom_range(0, 2000) - 1000);
      2: return $urandom_range(1) ? 18'h1FFFF : 18'h20000;
      default: return 18'($urandom);
    endcase
  endfunction

  // A random next support point.
  task automatic send_next();
    logic [17:0] x, y, z;
    x = rnd_coord(); y = rnd_coord(); z = rnd_coord();
    send_word(~gjk_pkg::CMD_START, x, y, z);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12)
        send_word(gjk_pkg::CMD_START, rnd_coord(), rnd_coord(), rnd_coord());
      else send_next();
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: next before any start, extremes, zero dot, separation, enclosure.
    send_word(~gjk_pkg::CMD_START, 18'd5, 18'd0, 18'd0);
    send_word(~gjk_pkg::CMD_START, 18'h3FFFB, 18'd0, 18'd0);
    send_word(~gjk_pkg::CMD_START, 18'd0, 18'd5, 18'd0);
    send_word(~gjk_pkg::CMD_START, 18'd0, 18'd0, 18'd5);
    send_word(~gjk_pkg::CMD_START, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    send_word(~gjk_pkg::CMD_START, 18'd1, 18'd1, 18'd1);
    send_word(gjk_pkg::CMD_START, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
    send_word(~gjk_pkg::CMD_START, 18'h20000, 18'h20000, 18'h20000);
    send_word(~gjk_pkg::CMD_START, 18'h1FFFF, 18'h20000, 18'h1FFFF);
    send_word(gjk_pkg::CMD_START, 18'd10, 18'd0, 18'd0);
    send_word(~gjk_pkg::CMD_START, 18'd0, 18'd7, 18'd0);
    send_word(~gjk_pkg::CMD_START, 18'd3, 18'd0, 18'd0);
    send_word(gjk_pkg::CMD_START, 18'd0, 18'd0, 18'd0);
    send_word(~gjk_pkg::CMD_START, 18'd0, 18'd0, 18'd0);
    send_word(gjk_pkg::CMD_START, 18'd10, 18'd0, 18'd0);
    send_word(~gjk_pkg::CMD_START, 18'd20, 18'd0, 18'd0);
    send_word(~gjk_pkg::CMD_START, 18'd1, 18'd1, 18'd1);
    drain();
    write_cap(11'd1);
    send_word(gjk_pkg::CMD_START, 18'd4, 18'd4, 18'd4);
    send_word(~gjk_pkg::CMD_START, 18'h3FFF0, 18'd2, 18'd1);
    send_word(~gjk_pkg::CMD_START, 18'd9, 18'd9, 18'd9);
    drain();
    write_cap(11'd0);
    send_word(gjk_pkg::CMD_START, 18'd4, 18'd4, 18'd4);
    send_word(~gjk_pkg::CMD_START, 18'h3FFF0, 18'd2, 18'd1);
    drain();

    // Random: several register settings and idling patterns.
    write_cap(11'd2047);
    send_idle_pct = 36; recv_idle_pct = 48;
    random_phase(650);
    drain();
    write_cap(11'd3);
    send_idle_pct = 48; recv_idle_pct = 36;
    random_phase(650);
    drain();
    write_cap(11'd1024);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(650);
    drain();

    $display("Checked %0d result words: %0d separated, %0d collided, %0d at the cap.",
             sb.checked, sb.n_sep, sb.n_coll, sb.n_lim);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("gjk_simplex_refinement verification clean");
    else
      $display("gjk_simplex_refinement verification failed");
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("gjk_simplex_refinement verification failed");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/gjk_pkg.sv
hw/rtl/gjk_simplex_refinement.sv
tb/tb_gjk_simplex_refinement.sv
